[hw/rtl/mhrk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mhrk_pkg;

	localparam int DEPTH_DEF = 256;

	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_REPLACE = 2'd1;
	localparam logic [1:0] FUNC_READ    = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] old_key;
		logic signed [31:0] new_key;
		logic [7:0]         read_index;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         position;
		logic signed [31:0] read_value;
		logic signed [31:0] root_key;
	} rsp_t;

	function automatic logic key_lt(input logic signed [31:0] a, input logic signed [31:0] b);
		return a < b;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/mhrk_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mhrk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = mhrk_pkg::DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/min_heap_replace_key.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  signals                       transfer
// req      in   req_valid, req_ready, req     req_valid & req_ready
// rsp      out  rsp_valid, rsp_ready, rsp     rsp_valid & rsp_ready
//
// One item at a time through one single-port-write, registered-read RAM.
// Load and read pass through the start and result states (a valid read adds a RAM
// wait state). Replace: linear search (one RAM read per entry), then per level sift up
// (read parent, compare) or sift down (read left, read right, compare); final write.
// Reset empties the heap (count zero); the store itself is not cleared.
// A pending response stalls only the final step; req_ready is high in idle.

module min_heap_replace_key #(
	parameter int DEPTH = mhrk_pkg::DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire mhrk_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output mhrk_pkg::rsp_t       rsp
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = IW + 1;
	localparam int XW = (CW > 8) ? CW : 8;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_START  = 11'b00000000010,
		ST_SEARCH = 11'b00000000100,
		ST_RDWAIT = 11'b00000001000,
		ST_UPRD   = 11'b00000010000,
		ST_UPCMP  = 11'b00000100000,
		ST_DNRDL  = 11'b00001000000,
		ST_DNRDR  = 11'b00010000000,
		ST_DNCMP  = 11'b00100000000,
		ST_FINAL  = 11'b01000000000,
		ST_RESULT = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      scan_q;
	logic               cmp_v_q;
	logic               first_q;
	logic               rsp_valid_q;
	logic [1:0]         func_q;
	logic signed [31:0] old_q;
	logic signed [31:0] new_q;
	logic [7:0]         ridx_q;
	logic [IW-1:0]      cmp_idx_q;
	logic [IW-1:0]      pos_q;
	logic signed [31:0] lv_q;
	logic               rok_q;
	logic [1:0]         status_q;
	logic signed [31:0] val_q;
	logic signed [31:0] root_q;
	mhrk_pkg::rsp_t     rsp_q;

	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic signed [31:0] ram_wdata;
	logic               ram_re;
	logic [IW-1:0]      ram_raddr;
	logic signed [31:0] ram_rdata;

	logic               full;
	logic               rd_ok;
	logic               found;
	logic               scan_more;
	logic [IW-1:0]      parent;
	logic [IW+1:0]      lft;
	logic [IW+1:0]      rgt;
	logic [IW+1:0]      cntx;
	logic               left_in;
	logic               right_in;
	logic               up_lt;
	logic               pick_r;
	logic signed [31:0] pv;
	logic [IW-1:0]      pidx;
	logic               dn_lt;
	logic               rsp_load;

	mhrk_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign full      = (cnt_q == CW'(DEPTH));
	assign rd_ok     = (XW'(ridx_q) < XW'(cnt_q));
	assign found     = cmp_v_q && (ram_rdata == old_q);
	assign scan_more = (scan_q < cnt_q);
	assign parent    = (pos_q - IW'(1)) >> 1;
	assign lft       = {1'b0, pos_q, 1'b1};
	assign rgt       = lft + (IW+2)'(1);
	assign cntx      = {1'b0, cnt_q};
	assign left_in   = (lft < cntx);
	assign right_in  = (rgt < cntx);
	assign up_lt     = mhrk_pkg::key_lt(new_q, ram_rdata);
	assign pick_r    = rok_q && mhrk_pkg::key_lt(ram_rdata, lv_q);
	assign pv        = pick_r ? ram_rdata : lv_q;
	assign pidx      = pick_r ? rgt[IW-1:0] : lft[IW-1:0];
	assign dn_lt     = mhrk_pkg::key_lt(pv, new_q);
	assign rsp_load  = (state_q == ST_RESULT) && (!rsp_valid_q || rsp_ready);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = new_q;
		ram_re    = 1'b0;
		ram_raddr = parent;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				case (func_q)
					mhrk_pkg::FUNC_LOAD: begin
						if (!full) begin
							ram_we    = 1'b1;
							ram_waddr = cnt_q[IW-1:0];
							ram_wdata = old_q;
						end
						state_d = ST_RESULT;
					end
					mhrk_pkg::FUNC_REPLACE: begin
						state_d = ST_SEARCH;
					end
					mhrk_pkg::FUNC_READ: begin
						if (rd_ok) begin
							ram_re    = 1'b1;
							ram_raddr = IW'(ridx_q);
							state_d   = ST_RDWAIT;
						end else begin
							state_d = ST_RESULT;
						end
					end
					default: begin
						state_d = ST_RESULT;
					end
				endcase
			end
			ST_SEARCH: begin
				if (found) begin
					state_d = ST_UPRD;
				end else if (scan_more) begin
					ram_re    = 1'b1;
					ram_raddr = scan_q[IW-1:0];
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_RDWAIT: begin
				state_d = ST_RESULT;
			end
			ST_UPRD: begin
				if (pos_q == '0) begin
					state_d = first_q ? ST_DNRDL : ST_FINAL;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = parent;
					state_d   = ST_UPCMP;
				end
			end
			ST_UPCMP: begin
				if (up_lt) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					state_d   = ST_UPRD;
				end else begin
					state_d = first_q ? ST_DNRDL : ST_FINAL;
				end
			end
			ST_DNRDL: begin
				if (left_in) begin
					ram_re    = 1'b1;
					ram_raddr = lft[IW-1:0];
					state_d   = ST_DNRDR;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_DNRDR: begin
				if (right_in) begin
					ram_re    = 1'b1;
					ram_raddr = rgt[IW-1:0];
				end
				state_d = ST_DNCMP;
			end
			ST_DNCMP: begin
				if (dn_lt) begin
					ram_we    = 1'b1;
					ram_wdata = pv;
					state_d   = ST_DNRDL;
				end else begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				ram_we  = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scan_q      <= '0;
			cmp_v_q     <= 1'b0;
			first_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_START) begin
				scan_q  <= '0;
				cmp_v_q <= 1'b0;
				first_q <= 1'b1;
				if (func_q == mhrk_pkg::FUNC_LOAD && !full) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (state_q == ST_SEARCH) begin
				if (!found && scan_more) begin
					cmp_v_q <= 1'b1;
					scan_q  <= scan_q + CW'(1);
				end else begin
					cmp_v_q <= 1'b0;
				end
			end
			if (state_q == ST_UPCMP && up_lt) begin
				first_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			func_q <= req.func;
			old_q  <= req.old_key;
			new_q  <= req.new_key;
			ridx_q <= req.read_index;
		end
		if (state_q == ST_START) begin
			status_q <= mhrk_pkg::STAT_OK;
			val_q    <= '0;
			pos_q    <= '0;
			if (func_q == mhrk_pkg::FUNC_LOAD) begin
				if (full) begin
					status_q <= mhrk_pkg::STAT_FULL;
				end else begin
					pos_q <= cnt_q[IW-1:0];
				end
			end
			if (func_q == mhrk_pkg::FUNC_READ && !rd_ok) begin
				status_q <= mhrk_pkg::STAT_BAD_INDEX;
			end
		end
		if (state_q == ST_SEARCH) begin
			if (found) begin
				pos_q <= cmp_idx_q;
			end else if (scan_more) begin
				cmp_idx_q <= scan_q[IW-1:0];
			end else begin
				status_q <= mhrk_pkg::STAT_NOT_FOUND;
			end
		end
		if (state_q == ST_RDWAIT) begin
			val_q <= ram_rdata;
		end
		if (state_q == ST_UPCMP && up_lt) begin
			pos_q <= parent;
		end
		if (state_q == ST_DNRDR) begin
			lv_q  <= ram_rdata;
			rok_q <= right_in;
		end
		if (state_q == ST_DNCMP && dn_lt) begin
			pos_q <= pidx;
		end
		if (ram_we && ram_waddr == '0) begin
			root_q <= ram_wdata;
		end
		if (rsp_load) begin
			rsp_q.status     <= status_q;
			rsp_q.position   <= (func_q == mhrk_pkg::FUNC_READ) ? ridx_q : 8'(pos_q);
			rsp_q.read_value <= val_q;
			rsp_q.root_key   <= (cnt_q != '0) ? root_q : 32'sd0;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> (cnt_q == $past(cnt_q) + CW'(1)) && $past(state_q == ST_START))
		else $error("entry count moved outside a load");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && (state_q != ST_START) |-> ({1'b0, ram_waddr} < cnt_q))
		else $error("sift write outside the heap");

	a_nf_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == mhrk_pkg::STAT_NOT_FOUND |-> rsp.position == 8'd0)
		else $error("missing key reported with a position");
`endif

endmodule

`default_nettype wire
